// ===== rtl/spc_pkg.sv =====
// Shared types and constants for the sequenced packet checker.
// Used by every module under rtl/; depends on nothing.
package spc_pkg;

   localparam int SPC_MAX_LEN    = 512;
   localparam int SPC_QDEPTH     = 4;
   localparam int SPC_QPTR_W     = $clog2(SPC_QDEPTH);
   localparam int SPC_QCNT_W     = $clog2(SPC_QDEPTH + 1);

   localparam logic [7:0]  MARKER_BYTE        = 8'hFF;
   localparam logic [15:0] CODE_ACK           = 16'hFFF2;
   localparam logic [15:0] CODE_REJECT        = 16'hFFF3;
   localparam logic [15:0] SUB_OUT_OF_SEQ     = 16'hFFF4;
   localparam logic [15:0] SUB_LENGTH_MISMATCH = 16'hFFF5;
   localparam logic [15:0] SUB_MARKER_MISSING = 16'hFFF6;
   localparam logic [15:0] SUB_DUPLICATE      = 16'hFFF7;

   localparam logic [3:0] ACK_LAST_IDX    = 4'd7;
   localparam logic [3:0] REJECT_LAST_IDX = 4'd9;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_datagram;
   } req_type;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       reply_last;
   } rsp_type;

   // One pending response frame.
   typedef struct packed {
      logic [7:0]  client_id;
      logic [7:0]  sequence_num;
      logic        is_reject;
      logic [15:0] sub_code;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fq_status_type;

endpackage

// ===== rtl/spc_parser.sv =====
// Per-byte datagram parser: header capture, end-marker scan and verdict.
// Pushes one frame descriptor per replied datagram. Depends on spc_pkg.
module spc_parser
   import spc_pkg::*;
#(
   parameter int MAX_LEN = SPC_MAX_LEN
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      item_valid,
   input  req_type   item,
   output logic      frame_push,
   output frame_type frame
);

   localparam int POS_W = $clog2(MAX_LEN + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       last_seq_ff, last_seq_in;
   logic [7:0]       cid_ff, cid_in;
   logic [7:0]       seq_ff, seq_in;
   logic [7:0]       len_ff, len_in;
   logic             prev_ff_ff, prev_ff_in;
   logic             found_ff, found_in;
   logic [8:0]       pcount_ff, pcount_in;

   logic        is_ff, hit, too_long, seq_match;
   logic [10:0] diff;
   logic [8:0]  expected;
   logic [15:0] sub;

   always_comb begin
      is_ff    = (item.data_byte == MARKER_BYTE);
      diff     = 11'(pos_ff) - 11'd8;
      hit      = (pos_ff >= POS_W'(8)) && prev_ff_ff && is_ff;
      too_long = (pos_ff >= POS_W'(MAX_LEN));

      cid_in = (pos_ff == POS_W'(2)) ? item.data_byte : cid_ff;
      seq_in = (pos_ff == POS_W'(5)) ? item.data_byte : seq_ff;
      len_in = (pos_ff == POS_W'(6)) ? item.data_byte : len_ff;

      found_in   = found_ff;
      pcount_in  = pcount_ff;
      prev_ff_in = prev_ff_ff;
      if (!found_ff) begin
         found_in   = hit;
         prev_ff_in = (pos_ff >= POS_W'(7)) && is_ff;
         if (hit) begin
            pcount_in = (diff > 11'd511) ? 9'd511 : diff[8:0];
         end
      end

      pos_in = too_long ? POS_W'(MAX_LEN) : pos_ff + POS_W'(1);

      // Compare in 9 bits: at 255 nothing matches.
      expected  = {1'b0, last_seq_ff} + 9'd1;
      seq_match = 1'b0;
      priority if ({1'b0, seq_in} > expected) begin
         sub = SUB_OUT_OF_SEQ;
      end else if ({1'b0, seq_in} < expected) begin
         sub = SUB_DUPLICATE;
      end else if (!found_in) begin
         sub = SUB_MARKER_MISSING;
      end else if (pcount_in != {1'b0, len_in}) begin
         sub = SUB_LENGTH_MISMATCH;
      end else begin
         sub       = CODE_ACK;
         seq_match = 1'b1;
      end

      frame_push         = item_valid && item.end_of_datagram && !too_long;
      frame.client_id    = cid_in;
      frame.sequence_num = seq_in;
      frame.is_reject    = !seq_match;
      frame.sub_code     = sub;

      last_seq_in = (frame_push && seq_match) ? last_seq_ff + 8'd1 : last_seq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         last_seq_ff <= '0;
         cid_ff      <= '0;
         seq_ff      <= '0;
         len_ff      <= '0;
         prev_ff_ff  <= 1'b0;
         found_ff    <= 1'b0;
         pcount_ff   <= '0;
      end else begin
         last_seq_ff <= last_seq_in;
         if (item_valid) begin
            if (item.end_of_datagram) begin
               pos_ff     <= '0;
               cid_ff     <= '0;
               seq_ff     <= '0;
               len_ff     <= '0;
               prev_ff_ff <= 1'b0;
               found_ff   <= 1'b0;
               pcount_ff  <= '0;
            end else begin
               pos_ff     <= pos_in;
               cid_ff     <= cid_in;
               seq_ff     <= seq_in;
               len_ff     <= len_in;
               prev_ff_ff <= prev_ff_in;
               found_ff   <= found_in;
               pcount_ff  <= pcount_in;
            end
         end
      end
   end

   a_pos_clear: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item.end_of_datagram) |=> (pos_ff == '0 && !found_ff))
      else $error("datagram state not cleared after final byte");

   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      (last_seq_ff != $past(last_seq_ff)) |-> $past(frame_push && !frame.is_reject))
      else $error("sequence counter moved without an ACK");

endmodule

// ===== rtl/spc_frame_queue.sv =====
// Small queue of pending response frame descriptors.
// Depends on spc_pkg.
module spc_frame_queue
   import spc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  frame_type     push_frame,
   input  logic          pop,
   output frame_type     head_frame,
   output fq_status_type status
);

   frame_type              slot_ff [SPC_QDEPTH];
   logic [SPC_QPTR_W-1:0]  wr_ff, rd_ff;
   logic [SPC_QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      status.full  = (count_ff == SPC_QCNT_W'(SPC_QDEPTH));
      status.empty = (count_ff == '0);
      head_frame   = slot_ff[rd_ff];
      count_in     = count_ff + SPC_QCNT_W'(push) - SPC_QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + SPC_QPTR_W'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + SPC_QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!status.full || pop))
      else $error("push into full frame queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty frame queue");

endmodule

// ===== rtl/spc_serializer.sv =====
// Turns queued frame descriptors into ACK / REJECT response bytes,
// one byte per transfer, behind an output register. Depends on spc_pkg.
module spc_serializer
   import spc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  frame_type     head_frame,
   input  fq_status_type status,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   logic       valid_ff, valid_in;
   rsp_type    data_ff, data_in;
   logic [3:0] idx_ff, idx_in;
   logic       load, at_last;
   logic [3:0] last_idx;
   logic [7:0] frame_byte;

   always_comb begin
      last_idx = head_frame.is_reject ? REJECT_LAST_IDX : ACK_LAST_IDX;
      at_last  = (idx_ff == last_idx);

      frame_byte = MARKER_BYTE;
      if (head_frame.is_reject) begin
         unique case (idx_ff)
            4'd2:    frame_byte = head_frame.client_id;
            4'd3:    frame_byte = CODE_REJECT[7:0];
            4'd4:    frame_byte = CODE_REJECT[15:8];
            4'd5:    frame_byte = head_frame.sub_code[7:0];
            4'd6:    frame_byte = head_frame.sub_code[15:8];
            4'd7:    frame_byte = head_frame.sequence_num;
            default: frame_byte = MARKER_BYTE;
         endcase
      end else begin
         unique case (idx_ff)
            4'd2:    frame_byte = head_frame.client_id;
            4'd3:    frame_byte = CODE_ACK[7:0];
            4'd4:    frame_byte = CODE_ACK[15:8];
            4'd5:    frame_byte = head_frame.sequence_num;
            default: frame_byte = MARKER_BYTE;
         endcase
      end

      load     = !valid_ff || rsp_ready;
      pop      = load && !status.empty && at_last;
      valid_in = valid_ff;
      data_in  = data_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in           = !status.empty;
         data_in.reply_byte = frame_byte;
         data_in.reply_last = at_last;
         if (!status.empty) begin
            idx_in = at_last ? 4'd0 : idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= REJECT_LAST_IDX)
      else $error("frame byte index out of range");

endmodule

// ===== rtl/sequenced_packet_checker.sv =====
// Top level of the sequenced packet checker: parser, frame queue, serializer.
// Depends on spc_pkg, spc_parser, spc_frame_queue, spc_serializer.
//
//   channel | direction | payload  | handshake
//   req_    | in        | req_type | req_valid / req_ready
//   rsp_    | out       | rsp_type | rsp_valid / rsp_ready
//
// A datagram byte is taken every cycle while the frame queue has room;
// the verdict is formed in the cycle the final byte is taken.
// A reply drains one byte per cycle from the output register while rsp_ready
// is high; ACK 8 bytes, REJECT 10: the port sets the long-run frame rate.
// Synchronous active-high reset clears all control state; no clearing pass.
// A stalled rsp_ready backs up the four-entry frame queue, then req_ready.
module sequenced_packet_checker
   import spc_pkg::*;
#(
   parameter int MAX_LEN = SPC_MAX_LEN
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic          frame_push, frame_pop;
   frame_type     new_frame, head_frame;
   fq_status_type fq_status;

   assign req_ready = !fq_status.full;

   spc_parser #(
      .MAX_LEN(MAX_LEN)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_valid && req_ready),
      .item       (req_data),
      .frame_push (frame_push),
      .frame      (new_frame)
   );

   spc_frame_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (frame_push),
      .push_frame (new_frame),
      .pop        (frame_pop),
      .head_frame (head_frame),
      .status     (fq_status)
   );

   spc_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .head_frame (head_frame),
      .status     (fq_status),
      .pop        (frame_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
